// ===== hdl/slrg_pkg.sv =====
// Package for the subtractive lagged random generator.
// Holds the command and micro-op codes, the control structs and the microcode ROM.
// No dependencies; the top level, datapath and testbench refer to it by scoped names.
package slrg_pkg;

  // Word and index sizes
  localparam int unsigned WORD_W = 31;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned STEP_W = 5;
  localparam int unsigned CNT_W  = 8;

  // Arithmetic constants of the scheme
  localparam logic [WORD_W-1:0] MODULUS   = 31'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] SEED_BASE = 31'd161803398;

  // Table walk constants (table words live at 1..55)
  localparam logic [IDX_W-1:0] TABLE_LAST      = 6'd55;
  localparam logic [IDX_W-1:0] SCATTER_STRIDE  = 6'd21;
  localparam logic [IDX_W-1:0] TRAIL_START     = 6'd21;
  // trail index one before the first mixing subtrahend (word 32)
  localparam logic [IDX_W-1:0] MIX_TRAIL_START = 6'd31;

  // Loop counts, loaded as count minus one
  localparam logic [CNT_W-1:0] SCAT_LOOPS = 8'd53;   // 54 scatter writes
  localparam logic [CNT_W-1:0] MIX_LOOPS  = 8'd219;  // 4 passes of 55 words

  // Input commands
  typedef enum logic [1:0] {
    CMD_DRAW   = 2'd0,
    CMD_RANGE  = 2'd1,
    CMD_RESEED = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // Datapath micro-ops
  typedef enum logic [3:0] {
    OP_FETCH,
    OP_RD,
    OP_WR,
    OP_MUL,
    OP_FOLD,
    OP_QUOT,
    OP_SCALE,
    OP_SEED,
    OP_SCAT,
    OP_MIXSET,
    OP_IDXSET,
    OP_EMIT_RAW,
    OP_EMIT_SCALED,
    OP_EMIT_ZERO
  } op_e;

  // Sequencer branch conditions
  typedef enum logic [1:0] {
    COND_NEXT,      // fall through
    COND_DISPATCH,  // wait for a beat, then branch on its command
    COND_LOOP,      // branch to target while the loop counter is nonzero
    COND_EMIT       // wait for a free output register, then branch to target
  } cond_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    op_e  op;
    logic in_take;
  } ctrl_t;

  // Microcode addresses
  localparam logic [STEP_W-1:0] ADDR_FETCH  = 5'd0;
  localparam logic [STEP_W-1:0] ADDR_DRAW   = 5'd1;
  localparam logic [STEP_W-1:0] ADDR_RANGE  = 5'd4;
  localparam logic [STEP_W-1:0] ADDR_SEED   = 5'd11;
  localparam logic [STEP_W-1:0] ADDR_SCAT   = 5'd12;
  localparam logic [STEP_W-1:0] ADDR_MIX_RD = 5'd14;
  localparam logic [STEP_W-1:0] ADDR_ZERO   = 5'd17;

  // Microcode program
  function automatic uword_t ucode_rom(input logic [STEP_W-1:0] addr);
    uword_t w;
    w = '{op: OP_FETCH, cond: COND_DISPATCH, target: ADDR_FETCH};
    unique case (addr)
      // idle, take a beat
      5'd0:  w = '{op: OP_FETCH,       cond: COND_DISPATCH, target: ADDR_FETCH};
      // raw draw
      5'd1:  w = '{op: OP_RD,          cond: COND_NEXT,     target: ADDR_FETCH};
      5'd2:  w = '{op: OP_WR,          cond: COND_NEXT,     target: ADDR_FETCH};
      5'd3:  w = '{op: OP_EMIT_RAW,    cond: COND_EMIT,     target: ADDR_FETCH};
      // ranged draw
      5'd4:  w = '{op: OP_RD,          cond: COND_NEXT,     target: ADDR_FETCH};
      5'd5:  w = '{op: OP_WR,          cond: COND_NEXT,     target: ADDR_FETCH};
      5'd6:  w = '{op: OP_MUL,         cond: COND_NEXT,     target: ADDR_FETCH};
      5'd7:  w = '{op: OP_FOLD,        cond: COND_NEXT,     target: ADDR_FETCH};
      5'd8:  w = '{op: OP_QUOT,        cond: COND_NEXT,     target: ADDR_FETCH};
      5'd9:  w = '{op: OP_SCALE,       cond: COND_NEXT,     target: ADDR_FETCH};
      5'd10: w = '{op: OP_EMIT_SCALED, cond: COND_EMIT,     target: ADDR_FETCH};
      // reseed: scatter, then mixing passes run as draws over the table
      5'd11: w = '{op: OP_SEED,        cond: COND_NEXT,     target: ADDR_FETCH};
      5'd12: w = '{op: OP_SCAT,        cond: COND_LOOP,     target: ADDR_SCAT};
      5'd13: w = '{op: OP_MIXSET,      cond: COND_NEXT,     target: ADDR_FETCH};
      5'd14: w = '{op: OP_RD,          cond: COND_NEXT,     target: ADDR_FETCH};
      5'd15: w = '{op: OP_WR,          cond: COND_LOOP,     target: ADDR_MIX_RD};
      5'd16: w = '{op: OP_IDXSET,      cond: COND_NEXT,     target: ADDR_FETCH};
      5'd17: w = '{op: OP_EMIT_ZERO,   cond: COND_EMIT,     target: ADDR_FETCH};
      default: w = '{op: OP_FETCH,     cond: COND_DISPATCH, target: ADDR_FETCH};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/subtractive_lagged_random_generator.sv =====
// Each input beat yields one result beat: a raw draw reads and rewrites one table word,
// a ranged draw then multiplies, folds and scales, a reseed makes 54 scatter writes and
// 220 mixing steps and then emits a zero, as does any other command. One item at a time:
// the input stalls until the result of the last item has gone into the output register.
// Reset (rst_ni, async low) clears the sequencer, indices, seed and output valid;
// the lag table is undefined until the first reseed.
module subtractive_lagged_random_generator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] min_value_i,
  input  logic signed [31:0] max_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_o,
  output logic [30:0]        raw_sample_o,
  input  logic               cfg_we_i,
  input  logic signed [31:0] cfg_wdata_i
);

  logic [slrg_pkg::STEP_W-1:0] step_q, step_d;
  logic [slrg_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  slrg_pkg::uword_t            uw;
  slrg_pkg::ctrl_t             ctrl;
  logic                        out_valid_q, out_valid_d;
  logic [31:0]                 value_q;
  logic [30:0]                 raw_q;
  logic                        out_free;
  logic                        emit_fire;
  logic                        in_take;
  logic [30:0]                 sample;
  logic [31:0]                 scaled;

  // Microcode fetch
  assign uw = slrg_pkg::ucode_rom(step_q);

  // Handshake and control outputs
  always_comb begin
    in_stall_o   = (uw.op != slrg_pkg::OP_FETCH);
    in_take      = in_valid_i && !in_stall_o;
    out_free     = !out_valid_q || !out_stall_i;
    emit_fire    = (uw.cond == slrg_pkg::COND_EMIT) && out_free;
    ctrl.op      = uw.op;
    ctrl.in_take = in_take;
  end

  // Next step and loop counter
  always_comb begin
    step_d = step_q + 5'd1;
    cnt_d  = cnt_q;
    unique case (uw.cond)
      slrg_pkg::COND_NEXT: begin
      end
      slrg_pkg::COND_DISPATCH: begin
        if (!in_valid_i) begin
          step_d = step_q;
        end else begin
          unique case (slrg_pkg::cmd_e'(cmd_i))
            slrg_pkg::CMD_DRAW:   step_d = slrg_pkg::ADDR_DRAW;
            slrg_pkg::CMD_RANGE:  step_d = slrg_pkg::ADDR_RANGE;
            slrg_pkg::CMD_RESEED: step_d = slrg_pkg::ADDR_SEED;
            slrg_pkg::CMD_NONE:   step_d = slrg_pkg::ADDR_ZERO;
            default:              step_d = slrg_pkg::ADDR_ZERO;
          endcase
        end
      end
      slrg_pkg::COND_LOOP: begin
        if (cnt_q != '0) begin
          step_d = uw.target;
          cnt_d  = cnt_q - 8'd1;
        end
      end
      slrg_pkg::COND_EMIT: begin
        step_d = out_free ? uw.target : step_q;
      end
      default: begin
      end
    endcase
    // loop counter loads
    if (uw.op == slrg_pkg::OP_SEED) begin
      cnt_d = slrg_pkg::SCAT_LOOPS;
    end else if (uw.op == slrg_pkg::OP_MIXSET) begin
      cnt_d = slrg_pkg::MIX_LOOPS;
    end
  end

  // Output valid: set on emit, held while stalled
  assign out_valid_d = emit_fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= slrg_pkg::ADDR_FETCH;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      unique case (uw.op)
        slrg_pkg::OP_EMIT_RAW: begin
          value_q <= {1'b0, sample};
          raw_q   <= sample;
        end
        slrg_pkg::OP_EMIT_SCALED: begin
          value_q <= scaled;
          raw_q   <= sample;
        end
        default: begin
          value_q <= '0;
          raw_q   <= '0;
        end
      endcase
    end
  end

  slrg_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .min_value_i (min_value_i),
    .max_value_i (max_value_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_o    (sample),
    .scaled_o    (scaled)
  );

  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign raw_sample_o = raw_q;

endmodule

// ===== hdl/slrg_dpath.sv =====
// Datapath of the subtractive lagged random generator: lag table memory,
// running indices, seed register, scatter state and the exact range scaler.
// Depends on slrg_pkg; driven one micro-op per cycle by the top-level sequencer.
module slrg_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slrg_pkg::ctrl_t     ctrl_i,
  input  logic [31:0]         min_value_i,
  input  logic [31:0]         max_value_i,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  output logic [30:0]         sample_o,
  output logic [31:0]         scaled_o
);

  localparam int unsigned TABLE_DEPTH = 56;

  // Lag table
  logic [30:0] lag_mem [TABLE_DEPTH];

  logic [30:0] seed_mag_q, seed_mag_d;
  logic [5:0]  lead_q, lead_d;
  logic [5:0]  trail_q, trail_d;
  logic [30:0] rd_a_q, rd_b_q;
  logic [30:0] sample_q;
  logic [31:0] min_q, range_q, rmag_q;
  logic [62:0] prod_q;
  logic [30:0] hi_q;
  logic [31:0] fold_q, quot_q, scaled_q;
  logic [30:0] mj_q, mk_q;
  logic [5:0]  sidx_q;

  logic [31:0] seed_abs;
  logic [31:0] base_minus, mag_minus;
  logic [30:0] seed_start;
  logic [30:0] diff;
  logic [6:0]  sidx_sum;
  logic [5:0]  sidx_nxt;
  logic [1:0]  corr;
  logic        mem_we;
  logic [5:0]  mem_waddr;
  logic [30:0] mem_wdata;

  // Cyclic step over table words 1..55
  function automatic logic [5:0] idx_next(input logic [5:0] idx);
    return (idx == slrg_pkg::TABLE_LAST) ? 6'd1 : idx + 6'd1;
  endfunction

  // (a - b) mod 2^31-1 for a, b below the modulus
  function automatic logic [30:0] sub_mod(input logic [30:0] a, input logic [30:0] b);
    logic [31:0] d;
    d = {1'b0, a} - {1'b0, b};
    return d[31] ? d[30:0] + slrg_pkg::MODULUS : d[30:0];
  endfunction

  // Seed magnitude, saturated at the modulus
  always_comb begin
    seed_abs   = cfg_wdata_i[31] ? (32'd0 - cfg_wdata_i) : cfg_wdata_i;
    seed_mag_d = seed_abs[31] ? slrg_pkg::MODULUS : seed_abs[30:0];
  end

  // Start word |base - |seed||
  always_comb begin
    base_minus = {1'b0, slrg_pkg::SEED_BASE} - {1'b0, seed_mag_q};
    mag_minus  = {1'b0, seed_mag_q} - {1'b0, slrg_pkg::SEED_BASE};
    seed_start = base_minus[31] ? mag_minus[30:0] : base_minus[30:0];
  end

  // Table difference, scatter index and quotient correction
  always_comb begin
    diff     = sub_mod(rd_a_q, rd_b_q);
    sidx_sum = {1'b0, sidx_q} + {1'b0, slrg_pkg::SCATTER_STRIDE};
    sidx_nxt = (sidx_sum >= {1'b0, slrg_pkg::TABLE_LAST}) ?
               6'(sidx_sum - {1'b0, slrg_pkg::TABLE_LAST}) : sidx_sum[5:0];
    if (fold_q >= {slrg_pkg::MODULUS, 1'b0}) begin
      corr = 2'd2;
    end else if (fold_q >= {1'b0, slrg_pkg::MODULUS}) begin
      corr = 2'd1;
    end else begin
      corr = 2'd0;
    end
  end

  // Running indices
  always_comb begin
    lead_d  = lead_q;
    trail_d = trail_q;
    unique case (ctrl_i.op)
      slrg_pkg::OP_RD: begin
        lead_d  = idx_next(lead_q);
        trail_d = idx_next(trail_q);
      end
      slrg_pkg::OP_MIXSET: begin
        lead_d  = '0;
        trail_d = slrg_pkg::MIX_TRAIL_START;
      end
      slrg_pkg::OP_IDXSET: begin
        lead_d  = '0;
        trail_d = slrg_pkg::TRAIL_START;
      end
      default: begin
      end
    endcase
  end

  // Table write port select
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = lead_q;
    mem_wdata = diff;
    unique case (ctrl_i.op)
      slrg_pkg::OP_WR: begin
        mem_we = 1'b1;
      end
      slrg_pkg::OP_SEED: begin
        mem_we    = 1'b1;
        mem_waddr = slrg_pkg::TABLE_LAST;
        mem_wdata = seed_start;
      end
      slrg_pkg::OP_SCAT: begin
        mem_we    = 1'b1;
        mem_waddr = sidx_q;
        mem_wdata = mk_q;
      end
      default: begin
      end
    endcase
  end

  // Table memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lag_mem[mem_waddr] <= mem_wdata;
    end
    if (ctrl_i.op == slrg_pkg::OP_RD) begin
      rd_a_q <= lag_mem[lead_d];
      rd_b_q <= lag_mem[trail_d];
    end
  end

  // Control state and seed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_mag_q <= '0;
      lead_q     <= '0;
      trail_q    <= slrg_pkg::TRAIL_START;
    end else begin
      if (cfg_we_i) begin
        seed_mag_q <= seed_mag_d;
      end
      lead_q  <= lead_d;
      trail_q <= trail_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.in_take) begin
      min_q   <= min_value_i;
      range_q <= max_value_i - min_value_i;
    end
    unique case (ctrl_i.op)
      slrg_pkg::OP_RD: begin
        rmag_q <= range_q[31] ? (32'd0 - range_q) : range_q;
      end
      slrg_pkg::OP_WR: begin
        sample_q <= diff;
      end
      slrg_pkg::OP_MUL: begin
        prod_q <= {32'd0, sample_q} * {31'd0, rmag_q};
      end
      slrg_pkg::OP_FOLD: begin
        // product stays below 2^62, so the high part fits 31 bits
        hi_q   <= prod_q[61:31];
        fold_q <= {1'b0, prod_q[61:31]} + {1'b0, prod_q[30:0]};
      end
      slrg_pkg::OP_QUOT: begin
        quot_q <= {1'b0, hi_q} + {30'd0, corr};
      end
      slrg_pkg::OP_SCALE: begin
        scaled_q <= range_q[31] ? (min_q - quot_q) : (min_q + quot_q);
      end
      slrg_pkg::OP_SEED: begin
        mj_q   <= seed_start;
        mk_q   <= 31'd1;
        sidx_q <= slrg_pkg::SCATTER_STRIDE;
      end
      slrg_pkg::OP_SCAT: begin
        mk_q   <= sub_mod(mj_q, mk_q);
        mj_q   <= mk_q;
        sidx_q <= sidx_nxt;
      end
      default: begin
      end
    endcase
  end

  assign sample_o = sample_q;
  assign scaled_o = scaled_q;

endmodule

// ===== hdl/slrg_chk.sv =====
// Port-level checker for the subtractive lagged random generator, with its bind.
// Depends on the top level's port list only.
module slrg_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] value_o,
  input logic [30:0] raw_sample_o
);

  logic       in_beat, out_beat;
  logic [1:0] pend_q;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_beat = out_valid_o && !out_stall_i;

  // Items taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_beat} - {1'b0, out_beat};
    end
  end

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o) && $stable(raw_sample_o))
    else $error("stalled result changed");

  // Block is busy right after taking a beat
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> in_stall_o)
    else $error("input not stalled after a beat");

  // At most one finished result waiting plus one item at work
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many items outstanding");

  // No result without an item
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result without a pending item");

endmodule

bind subtractive_lagged_random_generator slrg_chk u_slrg_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .value_o      (value_o),
  .raw_sample_o (raw_sample_o)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for subtractive_lagged_random_generator.
// Predicts every result beat from its own copy of the table, indices and seed.
// Depends on slrg_pkg for the command codes and the scheme constants.
module tb;

  localparam longint    MOD_L        = longint'(slrg_pkg::MODULUS);
  localparam int        MIX_LAG      = 30;
  localparam int        MIX_PASSES   = 4;
  localparam int        CYCLE_LIMIT  = 1_000_000;
  localparam int        PHASES       = 8;
  localparam int        PHASE_ITEMS  = 229;
  localparam int        HOLD_AT_BEAT = 100;
  localparam int        HOLD_CYCLES  = 300;

  typedef struct packed {
    slrg_pkg::cmd_e     cmd;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } gen_req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [30:0]        raw;
  } sample_t;

  // DUT connections
  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         cmd_i = slrg_pkg::CMD_NONE;
  logic signed [31:0] min_value_i = '0;
  logic signed [31:0] max_value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] value_o;
  logic [30:0]        raw_sample_o;
  logic               cfg_we_i = 1'b0;
  logic signed [31:0] cfg_wdata_i = '0;

  // Generator model state
  logic [30:0]        gen_table [56];
  logic [5:0]         lead_pos;
  logic [5:0]         trail_pos;
  logic signed [31:0] seed_reg;

  // Stimulus and checking state
  gen_req_t pending_items [$];
  sample_t  expected_samples [$];
  gen_req_t next_req;
  sample_t  want;
  int       errors = 0;
  int       src_gap = 0;
  int       rx_gap = 0;
  int       hold_left = 0;
  int       rx_beats = 0;
  int       idle_pct = 15;
  int       cycles = 0;
  bit       quiet = 1'b0;

  subtractive_lagged_random_generator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .min_value_i  (min_value_i),
    .max_value_i  (max_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .value_o      (value_o),
    .raw_sample_o (raw_sample_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Fill the table from the seed: stride-21 scatter, then lag-30 mixing passes
  function automatic void refill_table();
    longint mag, mj, mk, d;
    int     idx, tap;
    mag = longint'(seed_reg);
    if (mag < 0) mag = -mag;
    if (mag > MOD_L) mag = MOD_L;
    mj = longint'(slrg_pkg::SEED_BASE) - mag;
    if (mj < 0) mj = -mj;
    mj = mj % MOD_L;
    gen_table[slrg_pkg::TABLE_LAST] = mj[30:0];
    mk = 1;
    for (int i = 1; i < slrg_pkg::TABLE_LAST; i++) begin
      idx = (slrg_pkg::SCATTER_STRIDE * i) % slrg_pkg::TABLE_LAST;
      gen_table[idx] = mk[30:0];
      mk = mj - mk;
      if (mk < 0) mk += MOD_L;
      mj = longint'(gen_table[idx]);
    end
    for (int p = 0; p < MIX_PASSES; p++) begin
      for (int k = 1; k <= slrg_pkg::TABLE_LAST; k++) begin
        tap = 1 + ((k + MIX_LAG) % slrg_pkg::TABLE_LAST);
        d = longint'(gen_table[k]) - longint'(gen_table[tap]);
        if (d < 0) d += MOD_L;
        gen_table[k] = d[30:0];
      end
    end
    lead_pos  = '0;
    trail_pos = slrg_pkg::TRAIL_START;
  endfunction

  // Advance both indices over 1..55 and replace the lead word
  function automatic logic [30:0] step_generator();
    logic [5:0] nl, nt;
    longint     d;
    nl = (lead_pos >= slrg_pkg::TABLE_LAST) ? 6'd1 : lead_pos + 6'd1;
    nt = (trail_pos >= slrg_pkg::TABLE_LAST) ? 6'd1 : trail_pos + 6'd1;
    d = longint'(gen_table[nl]) - longint'(gen_table[nt]);
    if (d < 0) d += MOD_L;
    gen_table[nl] = d[30:0];
    lead_pos  = nl;
    trail_pos = nt;
    return d[30:0];
  endfunction

  // Result beat for one accepted command
  function automatic sample_t predict_beat(slrg_pkg::cmd_e c, logic signed [31:0] lo,
                                           logic signed [31:0] hi);
    sample_t            s;
    logic signed [31:0] span;
    longint             q;
    s.value = '0;
    s.raw   = '0;
    case (c)
      slrg_pkg::CMD_DRAW: begin
        s.raw   = step_generator();
        s.value = {1'b0, s.raw};
      end
      slrg_pkg::CMD_RANGE: begin
        s.raw   = step_generator();
        span    = hi - lo;  // wraps at 32 bits, read as signed
        q       = (longint'(s.raw) * longint'(span)) / MOD_L;
        s.value = q[31:0] + lo;
      end
      slrg_pkg::CMD_RESEED: refill_table();
      default: ;
    endcase
    return s;
  endfunction

  function automatic logic signed [31:0] pick_bound();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return int'($urandom_range(0, 200)) - 100;
      default: return $urandom;
    endcase
  endfunction

  function automatic gen_req_t pick_req();
    gen_req_t r;
    int       roll;
    roll  = $urandom_range(0, 99);
    r.lo  = pick_bound();
    r.hi  = pick_bound();
    if (roll < 45) r.cmd = slrg_pkg::CMD_DRAW;
    else if (roll < 91) r.cmd = slrg_pkg::CMD_RANGE;
    else if (roll < 95) r.cmd = slrg_pkg::CMD_NONE;
    else r.cmd = slrg_pkg::CMD_RESEED;
    return r;
  endfunction

  task automatic push_req(slrg_pkg::cmd_e c, logic signed [31:0] lo,
                          logic signed [31:0] hi);
    gen_req_t r;
    r.cmd = c;
    r.lo  = lo;
    r.hi  = hi;
    pending_items.push_back(r);
  endtask

  // Wait until every item has gone in and every result beat has come out
  task automatic drain();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_samples.size() != 0);
  endtask

  task automatic write_seed(logic signed [31:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    seed_reg = v;
  endtask

  // Driver: offers queued beats, with random gaps between them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      cmd_i       <= slrg_pkg::CMD_NONE;
      min_value_i <= '0;
      max_value_i <= '0;
      src_gap = 0;
      lead_pos  = '0;
      trail_pos = slrg_pkg::TRAIL_START;
      seed_reg  = '0;
    end else begin
      if (in_valid_i && !in_stall_o)
        expected_samples.push_back(predict_beat(slrg_pkg::cmd_e'(cmd_i),
                                                min_value_i, max_value_i));
      if (!in_valid_i || !in_stall_o) begin
        if (src_gap == 0 && !quiet && $urandom_range(0, 99) < idle_pct)
          src_gap = $urandom_range(1, 10);
        if (src_gap > 0) begin
          src_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() != 0) begin
          next_req = pending_items.pop_front();
          cmd_i       <= next_req.cmd;
          min_value_i <= next_req.lo;
          max_value_i <= next_req.hi;
          in_valid_i  <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result beat and drives the output stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_gap    = 0;
      hold_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        rx_beats++;
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected beat value=%0d raw=%0d", $time, value_o, raw_sample_o);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          if (value_o !== want.value) begin
            $display("%0t: value mismatch expected=%0d actual=%0d",
                     $time, want.value, value_o);
            errors++;
          end
          if (raw_sample_o !== want.raw) begin
            $display("%0t: raw_sample mismatch expected=%0d actual=%0d",
                     $time, want.raw, raw_sample_o);
            errors++;
          end
        end
        // one long hold so the block backs up and stalls its input
        if (rx_beats == HOLD_AT_BEAT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
        rx_gap = $urandom_range(1, 10) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** subtractive_lagged_random_generator: FAILED **");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    logic signed [31:0] seeds [PHASES];
    seeds[0] = 32'sd161803398;   // start word of zero
    seeds[1] = 32'sh8000_0000;   // magnitude saturates
    seeds[2] = 32'sh7FFF_FFFF;
    seeds[3] = -32'sd1;
    seeds[4] = 32'sd1;
    seeds[5] = -32'sd161803398;
    seeds[6] = $urandom;
    seeds[7] = $urandom;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: unused command before seeding, then draws, range corners and a second reseed
    push_req(slrg_pkg::CMD_NONE,   32'sh7FFF_FFFF, 32'sh8000_0000);
    push_req(slrg_pkg::CMD_RESEED, 0, 0);
    push_req(slrg_pkg::CMD_DRAW,   0, 0);
    push_req(slrg_pkg::CMD_DRAW,   -1, -1);
    push_req(slrg_pkg::CMD_RANGE,  0, 100);
    push_req(slrg_pkg::CMD_RANGE,  32'sh8000_0000, 32'sh7FFF_FFFF);  // range wraps to -1
    push_req(slrg_pkg::CMD_RANGE,  32'sh7FFF_FFFF, 32'sh8000_0000);  // range wraps to 1
    push_req(slrg_pkg::CMD_RANGE,  5, 5);
    push_req(slrg_pkg::CMD_RANGE,  10, -10);                         // negative range
    push_req(slrg_pkg::CMD_RANGE,  -100, 100);
    push_req(slrg_pkg::CMD_RANGE,  0, 32'sh7FFF_FFFF);
    push_req(slrg_pkg::CMD_RANGE,  32'sh8000_0000, 0);
    push_req(slrg_pkg::CMD_RANGE,  32'sh7FFF_FFFF, 32'sh7FFF_FFFE);  // range of -1 from the largest min
    push_req(slrg_pkg::CMD_NONE,   -1, -1);
    push_req(slrg_pkg::CMD_DRAW,   0, 0);
    push_req(slrg_pkg::CMD_RESEED, 0, 0);
    push_req(slrg_pkg::CMD_DRAW,   0, 0);
    drain();

    // Random phases, one seed setting each; idle-free stretches every third phase
    for (int p = 0; p < PHASES; p++) begin
      write_seed(seeds[p]);
      @(negedge clk_i);
      idle_pct = (p % 3 == 2) ? 0 : 15;
      quiet    = (p == PHASES - 1);
      push_req(slrg_pkg::CMD_RESEED, 0, 0);
      for (int n = 0; n < PHASE_ITEMS; n++)
        pending_items.push_back(pick_req());
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("** subtractive_lagged_random_generator: PASSED **");
    end else begin
      $display("** subtractive_lagged_random_generator: FAILED **");
    end
    $finish;
  end

endmodule
